// ===== sv/afhs_pkg.sv =====
// Package for the audio frame header scanner: sizes, mode and register codes,
// and the MPEG audio / ADTS header check functions.
// No dependencies.
package afhs_pkg;

  localparam int unsigned MAX_BUFFER_BYTES  = 4096;
  localparam int unsigned MPA_CHECK_BYTES   = 4;
  localparam int unsigned AAC_CHECK_BYTES   = 6;
  localparam int unsigned LPCM_HEADER_BYTES = 4;

  localparam int unsigned POS_W = $clog2(MAX_BUFFER_BYTES + 1);
  localparam int unsigned OFF_W = 12;
  localparam int unsigned CFG_W = 2;

  typedef enum logic [1:0] {
    MODE_MPA  = 2'd0,
    MODE_AAC  = 2'd1,
    MODE_LPCM = 2'd2,
    MODE_PASS = 2'd3
  } scan_mode_e;

  typedef enum logic {
    CFG_SCAN_MODE = 1'b0,
    CFG_END_POINT = 1'b1
  } cfg_idx_e;

  localparam logic [8:0] RATE_TABLE [5][15] = '{
    '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384},
    '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160}
  };

  localparam logic [8:0] BANNED_STEREO [4] = '{9'd32, 9'd48, 9'd56, 9'd80};
  localparam logic [8:0] BANNED_MONO   [4] = '{9'd224, 9'd256, 9'd320, 9'd384};

  // MPEG-1 picks a row per layer; MPEG-2 and MPEG-2.5 share rows 4 and 3.
  function automatic logic [2:0] rate_row(input logic [1:0] ver, input logic [1:0] lay);
    logic [2:0] row;
    if (ver == 2'd3) begin
      case (lay)
        2'd1:    row = 3'd2;
        2'd2:    row = 3'd1;
        default: row = 3'd0;
      endcase
    end else begin
      row = (lay == 2'd3) ? 3'd3 : 3'd4;
    end
    return row;
  endfunction

  function automatic logic mpa_ok(input logic [7:0] b0, input logic [7:0] b1,
                                  input logic [7:0] b2, input logic [7:0] b3);
    logic [1:0] ver;
    logic [1:0] lay;
    logic [3:0] bri;
    logic [1:0] sri;
    logic       mono;
    logic [8:0] rate;
    logic       ok;
    ver  = b1[4:3];
    lay  = b1[2:1];
    bri  = b2[7:4];
    sri  = b2[3:2];
    mono = (b3[6:5] == 2'd3);
    rate = (bri == 4'd15) ? 9'd0 : RATE_TABLE[rate_row(ver, lay)][bri];
    ok = (b0 == 8'hFF) && (b1[7:5] == 3'b111) && (ver != 2'd1) && (lay != 2'd0)
         && (bri != 4'd15) && (sri != 2'd3);
    for (int k = 0; k < 4; k++) begin
      if (rate == (mono ? BANNED_MONO[k] : BANNED_STEREO[k])) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic logic aac_ok(input logic [7:0] b0, input logic [7:0] b1,
                                  input logic [7:0] b2, input logic [7:0] b3,
                                  input logic [7:0] b4, input logic [7:0] b5);
    logic [12:0] len;
    len = {b3[1:0], b4, b5[7:5]};
    return (b0 == 8'hFF) && (b1[7:4] == 4'hF) && (b1[2:1] == 2'b00)
           && (b2[7:6] != 2'b11) && (b2[5:2] <= 4'd11) && (len != 13'd0);
  endfunction

endpackage

// ===== sv/audio_frame_header_scanner.sv =====
// Audio frame header scanner, top level.
// Depends on afhs_pkg for sizes, codes and the header check functions.
//
// Usage: stream the bytes of one buffer on the input channel (in_valid_i /
// in_ready_o, data_byte_i, last_byte_i), one byte per transfer, with
// last_byte_i set on the final byte. The block keeps the five previous
// bytes, a saturating byte position and the first header match, and emits
// one result transfer (header_found_o, sync_offset_o) per buffer.
// Mode and LPCM end point come from the write port (cfg_we_i, cfg_idx_i,
// cfg_data_i) and must be written between buffers.
// Throughput: one byte per cycle; the checks are a single pass of compares
// and a small rate table lookup between the window registers and the
// result register. Latency: the result is valid the cycle after the last
// byte transfers. The result register accepts new input while a result is
// taken in the same cycle; input stalls only while a result waits and the
// receiver holds out_ready_i low.
// Reset clears the window, position, match state, the result register and
// the mode registers (MPEG audio mode, header-skipping LPCM end point).
module audio_frame_header_scanner
  import afhs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             header_found_o,
  output logic [OFF_W-1:0] sync_offset_o
);

  scan_mode_e       mode_q;
  logic             end_point_q;
  logic [7:0]       win_q [5];
  logic [POS_W-1:0] pos_q, pos_d;
  logic             seen_q, seen_d;
  logic [OFF_W-1:0] off_q, off_d;
  logic             out_valid_q;
  logic             found_q, found_d;
  logic [OFF_W-1:0] res_off_q, res_off_d;

  logic             in_xfer;
  logic             in_range;
  logic             mpa_hit;
  logic             aac_hit;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign in_range   = (pos_q < POS_W'(MAX_BUFFER_BYTES));

  assign mpa_hit = (mode_q == MODE_MPA) && (pos_q >= POS_W'(3))
                   && mpa_ok(win_q[2], win_q[3], win_q[4], data_byte_i);
  assign aac_hit = (mode_q == MODE_AAC) && (pos_q >= POS_W'(5))
                   && aac_ok(win_q[0], win_q[1], win_q[2], win_q[3], win_q[4], data_byte_i);

  always_comb begin
    pos_d  = pos_q;
    seen_d = seen_q;
    off_d  = off_q;
    if (in_range) begin
      pos_d = pos_q + POS_W'(1);
      if (!seen_q && mpa_hit) begin
        seen_d = 1'b1;
        off_d  = OFF_W'(pos_q - POS_W'(3));
      end else if (!seen_q && aac_hit) begin
        seen_d = 1'b1;
        off_d  = OFF_W'(pos_q - POS_W'(5));
      end
    end
  end

  always_comb begin
    found_d   = 1'b0;
    res_off_d = '0;
    case (mode_q)
      MODE_MPA: begin
        if (seen_d && ({1'b0, off_d} + POS_W'(MPA_CHECK_BYTES) <= pos_d)) begin
          found_d   = 1'b1;
          res_off_d = off_d;
        end
      end
      MODE_AAC: begin
        if (seen_d && ({1'b0, off_d} + POS_W'(AAC_CHECK_BYTES) <= pos_d)) begin
          found_d   = 1'b1;
          res_off_d = off_d;
        end
      end
      MODE_LPCM: begin
        if (pos_d > POS_W'(LPCM_HEADER_BYTES)) begin
          found_d   = 1'b1;
          res_off_d = end_point_q ? '0 : OFF_W'(LPCM_HEADER_BYTES);
        end
      end
      default: begin
        found_d   = 1'b1;
        res_off_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_MPA;
      end_point_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SCAN_MODE: mode_q      <= scan_mode_e'(cfg_data_i);
        CFG_END_POINT: end_point_q <= cfg_data_i[0];
        default:       mode_q      <= mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 5; k++) begin
        win_q[k] <= '0;
      end
      pos_q  <= '0;
      seen_q <= 1'b0;
      off_q  <= '0;
    end else if (in_xfer) begin
      if (last_byte_i) begin
        for (int k = 0; k < 5; k++) begin
          win_q[k] <= '0;
        end
        pos_q  <= '0;
        seen_q <= 1'b0;
        off_q  <= '0;
      end else begin
        for (int k = 0; k < 4; k++) begin
          win_q[k] <= win_q[k+1];
        end
        win_q[4] <= data_byte_i;
        pos_q    <= pos_d;
        seen_q   <= seen_d;
        off_q    <= off_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer && last_byte_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q   <= 1'b0;
      res_off_q <= '0;
    end else if (in_xfer && last_byte_i) begin
      found_q   <= found_d;
      res_off_q <= res_off_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign header_found_o = found_q;
  assign sync_offset_o  = res_off_q;

  a_result_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && last_byte_i |=> out_valid_q)
    else $error("no result after last byte");

  a_pos_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(MAX_BUFFER_BYTES))
    else $error("byte position past limit");

  a_match_behind_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> ({1'b0, off_q} + POS_W'(MPA_CHECK_BYTES) <= pos_q))
    else $error("match offset ahead of position");

  a_no_match_zero_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !found_q |-> (res_off_q == '0))
    else $error("offset nonzero without header");

endmodule
